FILE: rtl/core/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg: shared types, constants and table builders
// Types for the spiral plotter ports, the queue entry, and the functions that
// build the sine and row tables at elaboration.
// ----------------------------------------------------------------------------
package spr_pkg;

  // Default geometry
  localparam int POINTS_DEF       = 200;
  localparam int COLUMNS_DEF      = 90;
  localparam int ROWS_DEF         = 10;
  localparam int PANEL_HEIGHT_DEF = 65;
  localparam int SINE_BITS_DEF    = 10;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_CENTER_COLUMN        = 3'd0,
    CFG_CENTER_HEIGHT_INCHES = 3'd1,
    CFG_RADIUS_COLUMNS       = 3'd2,
    CFG_RADIUS_INCHES        = 3'd3,
    CFG_TURNS_SIXTEENTHS     = 3'd4
  } spr_cfg_idx_t;

  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  localparam logic [7:0] ROW_INCHES [16] = '{8'd0, 8'd10, 8'd20, 8'd25, 8'd30, 8'd35,
                                             8'd40, 8'd45, 8'd55, 8'd65, 8'd255, 8'd255,
                                             8'd255, 8'd255, 8'd255, 8'd255};
  localparam logic [3:0] ROW_STRIP [16] = '{4'd4, 4'd5, 4'd3, 4'd6, 4'd7, 4'd8, 4'd9,
                                            4'd10, 4'd0, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0,
                                            4'd0, 4'd0};

  typedef struct packed {
    logic [7:0]  point_index;
    logic [15:0] rotation_phase;
    logic [31:0] time_ms;
  } spr_in_t;

  typedef struct packed {
    logic [3:0] strip_number;
    logic [6:0] led_position;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } spr_out_t;

  typedef struct packed {
    logic [6:0] center_column;
    logic [6:0] center_height_inches;
    logic [6:0] radius_columns;
    logic [6:0] radius_inches;
    logic [7:0] turns_sixteenths;
  } spr_cfg_t;

  // One classified point, as queued for the back end
  typedef struct packed {
    logic       on;
    logic [3:0] strip;
    logic [7:0] col;
    logic       has_plus;
    logic       has_minus;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } spr_entry_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic       valid;
    spr_entry_t entry;
  } spr_head_t;

  // Sine table entry k in Q1.15, folded to one quadrant, Taylor through x^13
  function automatic logic signed [15:0] sine_entry(int unsigned k, int unsigned bits);
    longint unsigned size, quarter, kk, quad, r, x, x2, term, sum, v;
    size    = 64'd1 << bits;
    quarter = size >> 2;
    kk      = longint'(k) & (size - 64'd1);
    quad    = kk >> (bits - 2);
    r       = kk & (quarter - 64'd1);
    if (quad[0]) r = quarter - r;
    x    = (r * TWO_PI_Q30) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
    v = (sum + 64'd16384) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return (quad >= 64'd2) ? -16'(v) : 16'(v);
  endfunction

  // Wired strip of the row nearest to height y; ties keep the lower row
  function automatic logic [3:0] strip_of_y(int unsigned y, int unsigned nrows);
    int unsigned best, row, d, i;
    best = (y > ROW_INCHES[0]) ? y - ROW_INCHES[0] : ROW_INCHES[0] - y;
    row  = 0;
    for (i = 1; i < nrows; i++) begin
      d = (y > ROW_INCHES[i]) ? y - ROW_INCHES[i] : ROW_INCHES[i] - y;
      if (d < best) begin
        best = d;
        row  = i;
      end
    end
    return ROW_STRIP[row[3:0]];
  endfunction

endpackage

FILE: rtl/core/spr_front.sv
// ----------------------------------------------------------------------------
// spr_front: point classifier pipeline
// Nine-stage pipeline that turns one spiral point into a queue entry: place,
// panel check, strip, edge flags and rainbow colour.
// ----------------------------------------------------------------------------
module spr_front #(
  parameter int POINTS          = spr_pkg::POINTS_DEF,
  parameter int COLUMNS         = spr_pkg::COLUMNS_DEF,
  parameter int ROWS            = spr_pkg::ROWS_DEF,
  parameter int PANEL_HEIGHT    = spr_pkg::PANEL_HEIGHT_DEF,
  parameter int SINE_TABLE_BITS = spr_pkg::SINE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  spr_pkg::spr_in_t   in_item,
  input  spr_pkg::spr_cfg_t  cfg,
  output logic               push,
  output spr_pkg::spr_entry_t push_entry
);
  import spr_pkg::*;

  localparam int SB       = SINE_TABLE_BITS;
  localparam int ROM_SIZE = 1 << SB;
  localparam int NROWS    = (ROWS < 16) ? ROWS : 16;
  localparam logic [SB-1:0] QUARTER = SB'(1) << (SB - 2);

  // Hue sectors
  localparam logic [2:0] SEC_R_TO_Y = 3'd0;
  localparam logic [2:0] SEC_Y_TO_G = 3'd1;
  localparam logic [2:0] SEC_G_TO_C = 3'd2;
  localparam logic [2:0] SEC_C_TO_B = 3'd3;
  localparam logic [2:0] SEC_B_TO_M = 3'd4;

  // Constant tables
  logic [15:0]        t16_tab   [256];
  logic [3:0]         strip_tab [256];
  logic signed [15:0] sine_rom  [ROM_SIZE];

  for (genvar g = 0; g < 256; g++) begin : g_tabs
    localparam int unsigned TV = ((g < POINTS ? g : POINTS - 1) * 65536) / POINTS;
    localparam logic [3:0] SV = strip_of_y(g, NROWS);
    assign t16_tab[g]   = 16'(TV);
    assign strip_tab[g] = SV;
  end

  for (genvar g = 0; g < ROM_SIZE; g++) begin : g_rom
    localparam logic signed [15:0] RV = sine_entry(g, SB);
    assign sine_rom[g] = RV;
  end

  // Truncate a Q31 sum toward zero
  function automatic logic signed [9:0] trunc_q31(logic signed [41:0] s);
    logic [41:0] mag;
    mag = 42'(-s) >> 31;
    if (s[41]) return -10'(mag);
    return 10'(s >>> 31);
  endfunction

  // Stage valids
  logic [9:1] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[8:1], in_fire};
    end
  end

  // Stage 1: t lookup, time folded modulo 1125 in two halves
  logic [15:0] t16_1_r, phase_1_r;
  logic [3:0]  tlo_1_r;
  logic [23:0] u_1_r;

  // Stage 2: products
  logic [15:0] phase_2_r;
  logic [23:0] angp_2_r;
  logic [31:0] bp_2_r;
  logic [30:0] hp_2_r;
  logic [47:0] qe_2_r;
  logic [23:0] u_2_r;
  logic [3:0]  tlo_2_r;
  logic [22:0] rct_2_r, rit_2_r;

  // Stage 3
  logic [SB-1:0] si_3_r, ci_3_r;
  logic [15:0]   b16_3_r;
  logic [14:0]   huet_3_r;
  logic [11:0]   rem_3_r;
  logic [3:0]    tlo_3_r;
  logic [22:0]   rct_3_r, rit_3_r;

  // Stage 4
  logic signed [15:0] sin_4_r, cos_4_r;
  logic [14:0]        r_4_r;
  logic [15:0]        b16_4_r;
  logic [14:0]        huet_4_r;
  logic [22:0]        rct_4_r, rit_4_r;

  // Stage 5
  logic signed [39:0] px_5_r, py_5_r;
  logic [40:0]        m2_5_r;
  logic [15:0]        b16_5_r;
  logic [14:0]        huet_5_r;

  // Stage 6
  logic signed [9:0] x_6_r, y_6_r;
  logic [15:0]       hue_6_r;
  logic [15:0]       b16_6_r;

  // Stage 7
  logic        on_7_r, hp_7_r, hm_7_r;
  logic [3:0]  strip_7_r;
  logic [7:0]  col_7_r;
  logic [14:0] hue_7_r;
  logic [15:0] b16_7_r;

  // Stage 8
  logic        on_8_r, hp_8_r, hm_8_r;
  logic [3:0]  strip_8_r;
  logic [7:0]  col_8_r;
  logic [2:0]  sec_8_r;
  logic [11:0] f_8_r;
  logic [15:0] b16_8_r;

  // Stage 9
  logic        on_9_r, hp_9_r, hm_9_r;
  logic [3:0]  strip_9_r;
  logic [7:0]  col_9_r;
  logic [2:0]  sec_9_r;
  logic [7:0]  full_9_r, rise_9_r, fall_9_r;

  logic [19:0]        ang_sum;
  logic [15:0]        ang;
  logic [13:0]        q_est;
  logic [11:0]        rem_c;
  logic signed [41:0] sum_x, sum_y;
  logic [15:0]        hue_sum;
  logic [2:0]         sec;
  logic [11:0]        n_fall;

  always_comb begin
    ang_sum = 20'(angp_2_r >> 4) + 20'(phase_2_r);
    ang     = ang_sum[15:0];
    q_est   = 14'(qe_2_r >> 34);
    rem_c   = (rem_3_r >= 12'd1125) ? rem_3_r - 12'd1125 : rem_3_r;
    sum_x   = {4'b0, cfg.center_column, 31'b0} + 42'(px_5_r);
    sum_y   = {4'b0, cfg.center_height_inches, 31'b0} + 42'(py_5_r);
    hue_sum = 16'(huet_5_r) + 16'(m2_5_r >> 25);
    sec     = 3'(hue_7_r >= 15'd3840) + 3'(hue_7_r >= 15'd7680) + 3'(hue_7_r >= 15'd11520)
            + 3'(hue_7_r >= 15'd15360) + 3'(hue_7_r >= 15'd19200);
    n_fall  = 12'd3840 - f_8_r;
  end

  // Advance the datapath every cycle
  always_ff @(posedge clk) begin
    // stage 1
    t16_1_r   <= t16_tab[in_item.point_index];
    phase_1_r <= in_item.rotation_phase;
    tlo_1_r   <= in_item.time_ms[3:0];
    u_1_r     <= 24'(in_item.time_ms[31:18] * 10'd634) + 24'(in_item.time_ms[17:4]);
    // stage 2
    phase_2_r <= phase_1_r;
    angp_2_r  <= t16_1_r * cfg.turns_sixteenths;
    bp_2_r    <= t16_1_r * 16'd45875;
    hp_2_r    <= t16_1_r * 15'd23040;
    qe_2_r    <= u_1_r * 24'd15270994;
    u_2_r     <= u_1_r;
    tlo_2_r   <= tlo_1_r;
    rct_2_r   <= cfg.radius_columns * t16_1_r;
    rit_2_r   <= cfg.radius_inches * t16_1_r;
    // stage 3
    si_3_r    <= ang[15 -: SB];
    ci_3_r    <= ang[15 -: SB] + QUARTER;
    b16_3_r   <= 16'(17'd19661 + 17'(bp_2_r >> 16));
    huet_3_r  <= 15'(hp_2_r >> 16);
    rem_3_r   <= 12'(u_2_r - 24'(q_est * 11'd1125));
    tlo_3_r   <= tlo_2_r;
    rct_3_r   <= rct_2_r;
    rit_3_r   <= rit_2_r;
    // stage 4
    sin_4_r   <= sine_rom[si_3_r];
    cos_4_r   <= sine_rom[ci_3_r];
    r_4_r     <= {rem_c[10:0], tlo_3_r};
    b16_4_r   <= b16_3_r;
    huet_4_r  <= huet_3_r;
    rct_4_r   <= rct_3_r;
    rit_4_r   <= rit_3_r;
    // stage 5
    px_5_r    <= $signed({1'b0, rct_4_r}) * cos_4_r;
    py_5_r    <= $signed({1'b0, rit_4_r}) * sin_4_r;
    m2_5_r    <= {r_4_r, 5'b0} * 21'd1342178;
    b16_5_r   <= b16_4_r;
    huet_5_r  <= huet_4_r;
    // stage 6
    x_6_r     <= trunc_q31(sum_x);
    y_6_r     <= trunc_q31(sum_y);
    hue_6_r   <= hue_sum;
    b16_6_r   <= b16_5_r;
    // stage 7
    on_7_r    <= (x_6_r >= 0) && (x_6_r < COLUMNS) && (y_6_r >= 0) && (y_6_r < PANEL_HEIGHT);
    hp_7_r    <= (int'(x_6_r) + 1) < COLUMNS;
    hm_7_r    <= x_6_r > 0;
    strip_7_r <= strip_tab[y_6_r[7:0]];
    col_7_r   <= x_6_r[7:0];
    hue_7_r   <= (hue_6_r >= 16'd23040) ? 15'(hue_6_r - 16'd23040) : hue_6_r[14:0];
    b16_7_r   <= b16_6_r;
    // stage 8
    on_8_r    <= on_7_r;
    hp_8_r    <= hp_7_r;
    hm_8_r    <= hm_7_r;
    strip_8_r <= strip_7_r;
    col_8_r   <= col_7_r;
    sec_8_r   <= sec;
    f_8_r     <= 12'(hue_7_r - 15'(sec * 12'd3840));
    b16_8_r   <= b16_7_r;
    // stage 9
    on_9_r    <= on_8_r;
    hp_9_r    <= hp_8_r;
    hm_9_r    <= hm_8_r;
    strip_9_r <= strip_8_r;
    col_9_r   <= col_8_r;
    sec_9_r   <= sec_8_r;
    full_9_r  <= 8'((33'd65280 * 33'(b16_8_r)) >> 24);
    rise_9_r  <= 8'((33'd17 * 33'(f_8_r) * 33'(b16_8_r)) >> 24);
    fall_9_r  <= 8'((33'd17 * 33'(n_fall) * 33'(b16_8_r)) >> 24);
  end

  // Pick channels by hue sector and push
  always_comb begin
    push_entry.on        = on_9_r;
    push_entry.strip     = strip_9_r;
    push_entry.col       = col_9_r;
    push_entry.has_plus  = hp_9_r;
    push_entry.has_minus = hm_9_r;
    case (sec_9_r)
      SEC_R_TO_Y: begin
        push_entry.red = full_9_r; push_entry.green = rise_9_r; push_entry.blue = '0;
      end
      SEC_Y_TO_G: begin
        push_entry.red = fall_9_r; push_entry.green = full_9_r; push_entry.blue = '0;
      end
      SEC_G_TO_C: begin
        push_entry.red = '0; push_entry.green = full_9_r; push_entry.blue = rise_9_r;
      end
      SEC_C_TO_B: begin
        push_entry.red = '0; push_entry.green = fall_9_r; push_entry.blue = full_9_r;
      end
      SEC_B_TO_M: begin
        push_entry.red = rise_9_r; push_entry.green = '0; push_entry.blue = full_9_r;
      end
      default: begin
        push_entry.red = full_9_r; push_entry.green = '0; push_entry.blue = fall_9_r;
      end
    endcase
  end

  assign push = v_r[9];

endmodule

FILE: rtl/core/spr_queue.sv
// ----------------------------------------------------------------------------
// spr_queue: point queue
// Register FIFO that decouples the classifier from the pixel writer.
// ----------------------------------------------------------------------------
module spr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  spr_pkg::spr_entry_t push_entry,
  input  logic                pop,
  output spr_pkg::spr_head_t  head
);
  import spr_pkg::*;

  spr_entry_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  assign head.valid = count_r != '0;
  assign head.entry = mem_r[rd_ptr_r];

endmodule

FILE: rtl/core/spr_back.sv
// ----------------------------------------------------------------------------
// spr_back: pixel writer
// Walks the queue head through the centre, right and left pixel writes.
// ----------------------------------------------------------------------------
module spr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  spr_pkg::spr_head_t head,
  output logic               pop,
  output logic               out_valid,
  output spr_pkg::spr_out_t  out_data
);
  import spr_pkg::*;

  typedef enum logic [1:0] {
    STEP_MID,
    STEP_RIGHT,
    STEP_LEFT
  } step_t;

  step_t      step_r, step_nxt;
  logic       emit, done;
  logic [6:0] col;

  // Choose this write's column and the next write
  always_comb begin
    emit     = head.valid && head.entry.on;
    col      = head.entry.col[6:0];
    step_nxt = STEP_MID;
    done     = 1'b1;
    unique case (step_r)
      STEP_MID: begin
        if (head.entry.has_plus) begin
          step_nxt = STEP_RIGHT; done = 1'b0;
        end else if (head.entry.has_minus) begin
          step_nxt = STEP_LEFT; done = 1'b0;
        end
      end
      STEP_RIGHT: begin
        col = head.entry.col[6:0] + 7'd1;
        if (head.entry.has_minus) begin
          step_nxt = STEP_LEFT; done = 1'b0;
        end
      end
      STEP_LEFT: begin
        col = head.entry.col[6:0] - 7'd1;
      end
      default: begin
        col = head.entry.col[6:0];
      end
    endcase
    pop = head.valid && (!head.entry.on || done);
  end

  // Hold step and drive the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= STEP_MID;
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit;
      if (emit) begin
        step_r                <= step_nxt;
        out_data.strip_number <= head.entry.strip;
        out_data.led_position <= col;
        out_data.red          <= head.entry.red;
        out_data.green        <= head.entry.green;
        out_data.blue         <= head.entry.blue;
        out_data.last         <= done;
      end
    end
  end

endmodule

FILE: rtl/core/spiral_point_rainbow_plotter.sv
// A point's first pixel write reaches the result ports through the classifier pipeline, the point
// queue and the writer's result register. Throughput: one pixel write per cycle from the single
// result port; a point has three writes, an edge point two and an off-panel point none.
// busy rises when 16 points are in flight (pipeline plus queue).
// Reset is synchronous and active low; it empties pipeline and queue and loads
// the register defaults. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// spiral_point_rainbow_plotter: spiral point plotter top level
// Holds the configuration registers and point credits and joins the
// classifier, the point queue and the pixel writer.
// ----------------------------------------------------------------------------
module spiral_point_rainbow_plotter #(
  parameter int POINTS          = spr_pkg::POINTS_DEF,
  parameter int COLUMNS         = spr_pkg::COLUMNS_DEF,
  parameter int ROWS            = spr_pkg::ROWS_DEF,
  parameter int PANEL_HEIGHT    = spr_pkg::PANEL_HEIGHT_DEF,
  parameter int SINE_TABLE_BITS = spr_pkg::SINE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  spr_pkg::spr_in_t  in_data,
  output logic              out_valid,
  output spr_pkg::spr_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import spr_pkg::*;

  spr_cfg_t          cfg_r;
  logic [QCNT_W-1:0] credit_r;
  logic              in_fire, push, pop;
  spr_entry_t        push_entry;
  spr_head_t         head;

  assign cfg_ready = 1'b1;
  assign in_fire   = start && !busy;
  assign busy      = credit_r == QCNT_W'(QUEUE_DEPTH);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_column        <= 7'd45;
      cfg_r.center_height_inches <= 7'd32;
      cfg_r.radius_columns       <= 7'd30;
      cfg_r.radius_inches        <= 7'd28;
      cfg_r.turns_sixteenths     <= 8'd56;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CENTER_COLUMN:        cfg_r.center_column        <= cfg_data[6:0];
        CFG_CENTER_HEIGHT_INCHES: cfg_r.center_height_inches <= cfg_data[6:0];
        CFG_RADIUS_COLUMNS:       cfg_r.radius_columns       <= cfg_data[6:0];
        CFG_RADIUS_INCHES:        cfg_r.radius_inches        <= cfg_data[6:0];
        CFG_TURNS_SIXTEENTHS:     cfg_r.turns_sixteenths     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Count points in flight: take on accept, return on queue pop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_r + QCNT_W'(in_fire) - QCNT_W'(pop);
    end
  end

  spr_front #(
    .POINTS          (POINTS),
    .COLUMNS         (COLUMNS),
    .ROWS            (ROWS),
    .PANEL_HEIGHT    (PANEL_HEIGHT),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_item    (in_data),
    .cfg        (cfg_r),
    .push       (push),
    .push_entry (push_entry)
  );

  spr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head)
  );

  spr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/spr_checker.sv
// ----------------------------------------------------------------------------
// spr_checker: port-level checks for the spiral plotter
// Watches the top level ports; bound to every instance of the top level.
// ----------------------------------------------------------------------------
module spr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              busy,
  input logic              out_valid,
  input spr_pkg::spr_out_t out_data
);

  // Reset empties the result register and frees all credits
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("result or busy left over after reset");

  // Writes of one point come back to back
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=> out_valid)
    else $error("gap inside one point's writes");

  // Writes of one point share strip and colour
  a_same_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=>
      out_data.strip_number == $past(out_data.strip_number) &&
      out_data.red == $past(out_data.red) &&
      out_data.green == $past(out_data.green) &&
      out_data.blue == $past(out_data.blue))
    else $error("strip or colour changed within a point");

  // Neighbor writes move to a new column
  a_new_column: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=>
      out_data.led_position != $past(out_data.led_position))
    else $error("repeated column within a point");

endmodule

bind spiral_point_rainbow_plotter spr_checker u_spr_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: spiral point plotter bench
// Drives spiral points in random bursts through several register settings,
// predicts every pixel write and checks each one as it leaves the block.
// ----------------------------------------------------------------------------
module testbench;
  import spr_pkg::*;

  localparam int N_POINTS  = 200;
  localparam int N_COLUMNS = 90;
  localparam int N_HEIGHT  = 65;
  localparam int N_ROWS    = 10;
  localparam int TAB_BITS  = 10;
  localparam int HUE_TURN  = 23040;
  localparam int HUE_SIX   = 3840;
  localparam int SETTLE    = 40;
  localparam int STALL_MAX = 3000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  spr_in_t  in_data = '0;
  logic     out_valid;
  spr_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  spiral_point_rainbow_plotter dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor copy of the registers
  spr_cfg_t  regs;
  int        sine_tab [1 << TAB_BITS];
  spr_out_t  pixel_q [$];
  int        errors = 0;
  int        idle_cycles = 0;

  const logic [7:0] row_height [10] = '{0, 10, 20, 25, 30, 35, 40, 45, 55, 65};
  const logic [3:0] row_wire [10]   = '{4, 5, 3, 6, 7, 8, 9, 10, 0, 2};

  // Directed rows; typed rows carry the first pixel of the point
  typedef struct {
    spr_in_t    pt;
    bit         typed;
    logic [3:0] strip;
    logic [6:0] led;
    logic [7:0] r, g, b;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    '{'{8'd0,   16'h0000, 32'd0},          1'b1, 4'd7, 7'd45, 8'd76, 8'd0, 8'd0},
    '{'{8'd0,   16'hFFFF, 32'hFFFFFFFF},   1'b0, 0, 0, 0, 0, 0},
    '{'{8'd199, 16'h0000, 32'd0},          1'b0, 0, 0, 0, 0, 0},
    '{'{8'd199, 16'hFFFF, 32'hFFFFFFFF},   1'b0, 0, 0, 0, 0, 0},
    '{'{8'd200, 16'h4000, 32'd3000},       1'b0, 0, 0, 0, 0, 0},
    '{'{8'd255, 16'h8000, 32'd6000},       1'b0, 0, 0, 0, 0, 0},
    '{'{8'd100, 16'hC000, 32'd9000},       1'b0, 0, 0, 0, 0, 0},
    '{'{8'd50,  16'h2000, 32'd12000},      1'b0, 0, 0, 0, 0, 0},
    '{'{8'd150, 16'h6000, 32'd15000},      1'b0, 0, 0, 0, 0, 0},
    '{'{8'd1,   16'hA000, 32'd17999},      1'b0, 0, 0, 0, 0, 0},
    '{'{8'd128, 16'hE000, 32'd18000},      1'b0, 0, 0, 0, 0, 0},
    '{'{8'd127, 16'h5555, 32'hAAAAAAAA},   1'b0, 0, 0, 0, 0, 0},
    '{'{8'd170, 16'hAAAA, 32'h55555555},   1'b0, 0, 0, 0, 0, 0},
    '{'{8'd85,  16'h1234, 32'h80000000},   1'b0, 0, 0, 0, 0, 0},
    '{'{8'd30,  16'hF000, 32'd1500},       1'b0, 0, 0, 0, 0, 0}
  };

  function automatic int sine_q15(int unsigned k);
    longint unsigned quarter, quad, r, x, x2, term, sum, v;
    quarter = 64'd1 << (TAB_BITS - 2);
    quad = k / quarter;
    r = k % quarter;
    if (quad[0]) r = quarter - r;
    x = (r * 64'd6746518852) >> TAB_BITS;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    v = (sum + 64'd16384) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return (quad >= 2) ? -int'(v) : int'(v);
  endfunction

  // Centre plus radius * t * trig, truncated toward zero
  function automatic longint spiral_coord(int unsigned c, int unsigned rad,
                                          int unsigned t16, int s);
    longint acc;
    acc = longint'(c) * 64'sd2147483648 + longint'(rad * t16) * longint'(s);
    return (acc >= 0) ? (acc >>> 31) : -((-acc) >>> 31);
  endfunction

  function automatic logic [7:0] chan_level(int unsigned n, int unsigned b16);
    return 8'((longint'(255) * n * b16) / (longint'(HUE_SIX) * 65536));
  endfunction

  // Work out the pixel writes of one point and queue them
  task automatic plot_point(spr_in_t pt);
    int unsigned idx, t16, ang, si, ci, b16, hue, f, best, d, row;
    longint x, y;
    logic [7:0] full, rise, fall, r, g, b;
    longint cols [$];
    spr_out_t px;
    idx = pt.point_index;
    if (idx >= N_POINTS) idx = N_POINTS - 1;
    t16 = (idx << 16) / N_POINTS;
    ang = (((t16 * regs.turns_sixteenths) >> 4) + pt.rotation_phase) & 32'hFFFF;
    si = ang >> (16 - TAB_BITS);
    ci = (si + (1 << (TAB_BITS - 2))) & ((1 << TAB_BITS) - 1);
    x = spiral_coord(regs.center_column, regs.radius_columns, t16, sine_tab[ci]);
    y = spiral_coord(regs.center_height_inches, regs.radius_inches, t16, sine_tab[si]);
    if (x < 0 || x >= N_COLUMNS || y < 0 || y >= N_HEIGHT) return;
    row = 0;
    best = (y > row_height[0]) ? y - row_height[0] : row_height[0] - y;
    for (int i = 1; i < N_ROWS; i++) begin
      d = (y > row_height[i]) ? y - row_height[i] : row_height[i] - y;
      if (d < best) begin
        best = d;
        row = i;
      end
    end
    b16 = 19661 + int'((longint'(45875) * t16) >> 16);
    hue = int'((longint'(t16) * HUE_TURN) >> 16)
        + int'(((longint'(pt.time_ms) * 32) / 25) % HUE_TURN);
    hue = hue % HUE_TURN;
    f = hue % HUE_SIX;
    full = chan_level(HUE_SIX, b16);
    rise = chan_level(f, b16);
    fall = chan_level(HUE_SIX - f, b16);
    case (hue / HUE_SIX)
      0: begin r = full; g = rise; b = 0; end
      1: begin r = fall; g = full; b = 0; end
      2: begin r = 0; g = full; b = rise; end
      3: begin r = 0; g = fall; b = full; end
      4: begin r = rise; g = 0; b = full; end
      default: begin r = full; g = 0; b = fall; end
    endcase
    cols.push_back(x);
    if (x + 1 < N_COLUMNS) cols.push_back(x + 1);
    if (x > 0) cols.push_back(x - 1);
    foreach (cols[k]) begin
      px = '{row_wire[row], 7'(cols[k]), r, g, b, k == cols.size() - 1};
      pixel_q.push_back(px);
    end
  endtask

  task automatic report(string what, spr_out_t got, spr_out_t want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Check each pixel write against the oldest expectation
  always @(posedge clk) begin
    spr_out_t want;
    if (rst_n && out_valid) begin
      if (pixel_q.size() == 0) begin
        report("unexpected pixel", out_data, '0);
      end else begin
        want = pixel_q.pop_front();
        if (out_data.strip_number !== want.strip_number) report("strip", out_data, want);
        if (out_data.led_position !== want.led_position) report("led", out_data, want);
        if (out_data.red !== want.red) report("red", out_data, want);
        if (out_data.green !== want.green) report("green", out_data, want);
        if (out_data.blue !== want.blue) report("blue", out_data, want);
        if (out_data.last !== want.last) report("last", out_data, want);
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_MAX) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Transfer one point; start stays high for a following point
  task automatic send_point(spr_in_t pt, bit typed, dir_row_t row);
    @(negedge clk);
    start <= 1'b1;
    in_data <= pt;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (typed) begin
      pixel_q.push_back('{row.strip, row.led, row.r, row.g, row.b, 1'b0});
      pixel_q.push_back('{row.strip, row.led + 7'd1, row.r, row.g, row.b, 1'b0});
      pixel_q.push_back('{row.strip, row.led - 7'd1, row.r, row.g, row.b, 1'b1});
    end else begin
      plot_point(pt);
    end
  endtask

  task automatic pause(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Wait for every write, then let off-panel points drain too
  task automatic drain();
    pause(0);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(spr_cfg_idx_t idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_CENTER_COLUMN:        regs.center_column = val[6:0];
      CFG_CENTER_HEIGHT_INCHES: regs.center_height_inches = val[6:0];
      CFG_RADIUS_COLUMNS:       regs.radius_columns = val[6:0];
      CFG_RADIUS_INCHES:        regs.radius_inches = val[6:0];
      default:                  regs.turns_sixteenths = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(int cc, int ch, int rc, int ri, int ts);
    write_reg(CFG_CENTER_COLUMN, 8'(cc));
    write_reg(CFG_CENTER_HEIGHT_INCHES, 8'(ch));
    write_reg(CFG_RADIUS_COLUMNS, 8'(rc));
    write_reg(CFG_RADIUS_INCHES, 8'(ri));
    write_reg(CFG_TURNS_SIXTEENTHS, 8'(ts));
  endtask

  initial begin
    spr_in_t  pt;
    dir_row_t none;
    int burst;
    none = '{'0, 1'b0, 0, 0, 0, 0, 0};
    regs = '{7'd45, 7'd32, 7'd30, 7'd28, 8'd56};
    for (int k = 0; k < (1 << TAB_BITS); k++) sine_tab[k] = sine_q15(k);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed points at the reset settings
    foreach (dir_rows[i]) begin
      send_point(dir_rows[i].pt, dir_rows[i].typed, dir_rows[i]);
      if ($urandom_range(3) == 0) pause($urandom_range(4));
    end

    // Random points over a series of register settings
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: load_regs(0, 0, 0, 0, 0);
        1: load_regs(89, 64, 89, 64, 255);
        2: load_regs(0, 32, 0, 28, 56);
        3: load_regs(89, 10, 0, 0, 16);
        4: load_regs(127, 127, 127, 127, 255);
        5: load_regs(45, 32, 30, 28, 56);
        default: load_regs($urandom_range(89), $urandom_range(64),
                           $urandom_range(89), $urandom_range(64), $urandom_range(255));
      endcase
      for (int n = 0; n < 36; ) begin
        burst = $urandom_range(1, 8);
        for (int j = 0; j < burst; j++, n++) begin
          pt.point_index = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(199));
          pt.rotation_phase = 16'($urandom);
          pt.time_ms = $urandom;
          send_point(pt, 1'b0, none);
        end
        if ($urandom_range(3) != 0) pause($urandom_range(12));
      end
    end

    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
